/* rtl/i2c_master_bit_engine_core_defines.svh */
// ---------------------------------------------------------------------------
// I2C master bit engine - assertion macros
// Shared property templates for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define I2CMBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define I2CMBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/i2cmbe_pkg.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - package
// Field widths, command codes, register indexes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  // commands
  localparam logic [OP_W-1:0] CMD_NONE   = 3'd0;
  localparam logic [OP_W-1:0] CMD_START  = 3'd1;
  localparam logic [OP_W-1:0] CMD_WRITE  = 3'd2;
  localparam logic [OP_W-1:0] CMD_RD_ACK = 3'd3;
  localparam logic [OP_W-1:0] CMD_RD_NAK = 3'd4;
  localparam logic [OP_W-1:0] CMD_STOP   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRETCH = 2'd2;

  localparam logic [CFG_W-1:0] BASE_RST    = 16'd12;
  localparam logic [CFG_W-1:0] SETTLE_RST  = 16'd1;
  localparam logic [CFG_W-1:0] STRETCH_RST = 16'd500;

  // tick queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [CFG_W-1:0] base_ticks;
    logic [CFG_W-1:0] settle_ticks;
    logic [CFG_W-1:0] stretch_limit;
  } cfg_t;

  // one classified tick
  typedef struct packed {
    logic              cmd_vld;
    logic [OP_W-1:0]   cmd;
    logic [BYTE_W-1:0] wr_byte;
    logic              scl;
    logic              sda;
  } tick_t;

  typedef struct packed {
    logic vld;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic              scl_low;
    logic              sda_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rd_byte;
    logic              ack_seen;
    logic              stretch_timeout;
  } res_t;

endpackage

`default_nettype wire

/* rtl/i2cmbe_if.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - channel interfaces
// Valid/ready channels for ticks in and line/status results out.
// ---------------------------------------------------------------------------
`default_nettype none

interface i2cmbe_in_if;
  logic                           valid;
  logic                           ready;
  logic [i2cmbe_pkg::OP_W-1:0]    op;
  logic [i2cmbe_pkg::BYTE_W-1:0]  wr_byte;
  logic                           scl_in;
  logic                           sda_in;

  modport source (output valid, output op, output wr_byte, output scl_in,
                  output sda_in, input ready);
  modport sink   (input valid, input op, input wr_byte, input scl_in,
                  input sda_in, output ready);
endinterface

interface i2cmbe_out_if;
  logic                           valid;
  logic                           ready;
  logic                           scl_low;
  logic                           sda_low;
  logic                           busy_res;
  logic                           done_res;
  logic [i2cmbe_pkg::BYTE_W-1:0]  rd_byte;
  logic                           ack_seen;
  logic                           stretch_timeout;

  modport source (output valid, output scl_low, output sda_low, output busy_res,
                  output done_res, output rd_byte, output ack_seen,
                  output stretch_timeout, input ready);
  modport sink   (input valid, input scl_low, input sda_low, input busy_res,
                  input done_res, input rd_byte, input ack_seen,
                  input stretch_timeout, output ready);
endinterface

`default_nettype wire

/* rtl/i2c_master_bit_engine_core.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - top level
// Open-drain I2C master bit engine driven by one timer tick per transaction.
// ---------------------------------------------------------------------------
// Each input transaction is one timer tick carrying the sampled SCL/SDA levels
// and, while the engine is idle, a command (start, write byte + ACK sample,
// read byte + ACK or NAK, stop). Every tick yields exactly one result
// transaction with the line drives, busy, done, the last read byte, the ACK
// flag and the stretch timeout flag. The engine takes one tick per clock,
// back to back, while the queue is not full. The front end classifies a taken
// tick into a two-entry queue, the back end steps the sequencer and registers
// the result. If the result side stalls, the queue absorbs up to two more
// ticks before in_ch.ready drops. Phase lengths come from base_ticks and
// settle_ticks, clock stretching is waited out up to stretch_limit ticks; all
// timers saturate at 2^COUNTER_BITS - 1. Configuration is written through
// cfg_we/cfg_idx/cfg_wdata; the user must do so only while idle, which the
// block itself does not enforce.
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_core #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  i2cmbe_in_if.sink                            in_ch,
  i2cmbe_out_if.source                         out_ch,
  input  logic                                 cfg_we,
  input  logic [i2cmbe_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [i2cmbe_pkg::CFG_W-1:0]         cfg_wdata
);

  i2cmbe_pkg::cfg_t     cfg_r, cfg_nxt;
  i2cmbe_pkg::tick_t    push_item, head;
  i2cmbe_pkg::q_stat_t  q_stat;
  logic                 push, pop;

  // register file; unused index is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        i2cmbe_pkg::CFG_BASE:    cfg_nxt.base_ticks    = cfg_wdata;
        i2cmbe_pkg::CFG_SETTLE:  cfg_nxt.settle_ticks  = cfg_wdata;
        i2cmbe_pkg::CFG_STRETCH: cfg_nxt.stretch_limit = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_ticks    <= i2cmbe_pkg::BASE_RST;
      cfg_r.settle_ticks  <= i2cmbe_pkg::SETTLE_RST;
      cfg_r.stretch_limit <= i2cmbe_pkg::STRETCH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: accept and classify
  i2cmbe_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  i2cmbe_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // back end: bit sequencer and result register
  i2cmbe_back #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

/* rtl/i2cmbe_front.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - front end
// Accepts tick transactions and classifies the command code.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cmbe_front (
  i2cmbe_in_if.sink            in_ch,
  input  i2cmbe_pkg::q_stat_t  q_stat,
  output logic                 push,
  output i2cmbe_pkg::tick_t    push_item
);

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    push_item.cmd     = in_ch.op;
    push_item.wr_byte = in_ch.wr_byte;
    push_item.scl     = in_ch.scl_in;
    push_item.sda     = in_ch.sda_in;
    unique case (in_ch.op) inside
      i2cmbe_pkg::CMD_START, i2cmbe_pkg::CMD_WRITE, i2cmbe_pkg::CMD_RD_ACK,
      i2cmbe_pkg::CMD_RD_NAK, i2cmbe_pkg::CMD_STOP: push_item.cmd_vld = 1'b1;
      default:                                      push_item.cmd_vld = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/i2cmbe_queue.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - tick queue
// Small FIFO decoupling the front end from the engine.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cmbe_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  i2cmbe_pkg::tick_t    push_item,
  input  logic                 pop,
  output i2cmbe_pkg::tick_t    head,
  output i2cmbe_pkg::q_stat_t  q_stat
);

  i2cmbe_pkg::tick_t                  entries_r [i2cmbe_pkg::QDEPTH];
  logic [i2cmbe_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [i2cmbe_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [i2cmbe_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  assign head        = entries_r[rd_ptr_r];
  assign q_stat.vld  = cnt_r != '0;
  assign q_stat.full = cnt_r == i2cmbe_pkg::QCNT_W'(i2cmbe_pkg::QDEPTH);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* rtl/i2cmbe_back.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - back end
// Bit-level sequencer, phase timer and the result output register.
// ---------------------------------------------------------------------------
`default_nettype none

module i2cmbe_back #(
  parameter int COUNTER_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  i2cmbe_pkg::cfg_t     cfg,
  input  i2cmbe_pkg::tick_t    head,
  input  i2cmbe_pkg::q_stat_t  q_stat,
  output logic                 pop,
  i2cmbe_out_if.source         out_ch
);

  localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_S_HOLD    = 4'd1;
  localparam logic [3:0] PH_S_SDA     = 4'd2;
  localparam logic [3:0] PH_SETTLE    = 4'd3;
  localparam logic [3:0] PH_STRETCH   = 4'd4;
  localparam logic [3:0] PH_HIGH1     = 4'd5;
  localparam logic [3:0] PH_HIGH2     = 4'd6;
  localparam logic [3:0] PH_LOW1      = 4'd7;
  localparam logic [3:0] PH_LOW2      = 4'd8;
  localparam logic [3:0] PH_STOP_SET  = 4'd9;
  localparam logic [3:0] PH_STOP_HOLD = 4'd10;

  // clamp a 16-bit setting to the counter range
  function automatic logic [COUNTER_BITS-1:0] sat_cnt(input logic [i2cmbe_pkg::CFG_W-1:0] n);
    sat_cnt = (32'(n) > 32'(CNT_MAX)) ? CNT_MAX : COUNTER_BITS'(n);
  endfunction

  logic [3:0]                        phase_r, phase_nxt;
  logic [i2cmbe_pkg::OP_W-1:0]       cmd_r, cmd_nxt;
  logic [3:0]                        bit_r, bit_nxt;
  logic [i2cmbe_pkg::BYTE_W-1:0]     shift_r, shift_nxt;
  logic [i2cmbe_pkg::BYTE_W-1:0]     rd_r, rd_nxt;
  logic [COUNTER_BITS-1:0]           tick_r, tick_nxt;
  logic [COUNTER_BITS-1:0]           str_r, str_nxt;
  logic                              scl_r, scl_nxt;
  logic                              sda_r, sda_nxt;
  logic                              ack_r, ack_nxt;
  logic                              tout_r, tout_nxt;
  logic                              done;

  logic                              out_vld_r, out_vld_nxt;
  i2cmbe_pkg::res_t                  out_r, res;

  logic [i2cmbe_pkg::CFG_W-1:0]      wait_n;
  logic [COUNTER_BITS-1:0]           wait_sat, wait_lim, tick_inc, str_lim;
  logic                              wait_hit;
  logic [3:0]                        bit_inc;
  logic [i2cmbe_pkg::BYTE_W-1:0]     shift_in;
  logic                              is_rd;

  assign pop = q_stat.vld && (!out_vld_r || out_ch.ready);

  // shared phase timer
  assign wait_n   = (phase_r == PH_SETTLE || phase_r == PH_STOP_SET) ?
                    cfg.settle_ticks : cfg.base_ticks;
  assign wait_sat = sat_cnt(wait_n);
  assign wait_lim = (wait_sat == '0) ? COUNTER_BITS'(1) : wait_sat;
  assign tick_inc = tick_r + COUNTER_BITS'(1);
  assign wait_hit = tick_inc >= wait_lim;
  assign str_lim  = sat_cnt(cfg.stretch_limit);

  assign bit_inc  = bit_r + 4'd1;
  assign shift_in = {shift_r[i2cmbe_pkg::BYTE_W-2:0], head.sda};
  assign is_rd    = cmd_r == i2cmbe_pkg::CMD_RD_ACK || cmd_r == i2cmbe_pkg::CMD_RD_NAK;

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    rd_nxt    = rd_r;
    tick_nxt  = tick_r;
    str_nxt   = str_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    tout_nxt  = tout_r;
    done      = 1'b0;

    if (pop) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (head.cmd_vld) begin
            cmd_nxt  = head.cmd;
            tout_nxt = 1'b0;
            tick_nxt = '0;
            unique case (head.cmd) inside
              i2cmbe_pkg::CMD_START: begin
                scl_nxt   = 1'b0;
                sda_nxt   = 1'b0;
                bit_nxt   = 4'd8;
                phase_nxt = PH_S_HOLD;
              end
              i2cmbe_pkg::CMD_STOP: begin
                scl_nxt   = 1'b1;
                sda_nxt   = 1'b1;
                phase_nxt = PH_STOP_SET;
              end
              i2cmbe_pkg::CMD_WRITE, i2cmbe_pkg::CMD_RD_ACK, i2cmbe_pkg::CMD_RD_NAK: begin
                if (head.cmd == i2cmbe_pkg::CMD_WRITE) begin
                  shift_nxt = head.wr_byte;
                  ack_nxt   = 1'b0;
                end else begin
                  shift_nxt = '0;
                end
                scl_nxt   = 1'b1;
                sda_nxt   = 1'b1;
                bit_nxt   = 4'd15;
                phase_nxt = PH_LOW1;
              end
              default: ;
            endcase
          end
        end
        PH_S_HOLD: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            sda_nxt   = 1'b1;
            phase_nxt = PH_S_SDA;
          end
        end
        PH_S_SDA: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_LOW1;
          end
        end
        PH_SETTLE, PH_STOP_SET: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            scl_nxt   = 1'b0;
            str_nxt   = '0;
            phase_nxt = PH_STRETCH;
          end
        end
        PH_STRETCH: begin
          if (!head.scl && str_r < str_lim) begin
            str_nxt = str_r + COUNTER_BITS'(1);
          end else begin
            if (!head.scl) begin
              tout_nxt = 1'b1;
            end
            tick_nxt  = '0;
            phase_nxt = (cmd_r == i2cmbe_pkg::CMD_STOP) ? PH_STOP_HOLD : PH_HIGH1;
          end
        end
        PH_HIGH1: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            if (is_rd && bit_r < 4'd8) begin
              shift_nxt = shift_in;
              if (bit_r == 4'd7) begin
                rd_nxt = shift_in;
              end
            end else if (cmd_r == i2cmbe_pkg::CMD_WRITE && bit_r == 4'd8) begin
              ack_nxt = !head.sda;
            end
            phase_nxt = PH_HIGH2;
          end
        end
        PH_HIGH2: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            scl_nxt   = 1'b1;
            phase_nxt = PH_LOW1;
          end
        end
        PH_LOW1: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            phase_nxt = PH_LOW2;
          end
        end
        PH_LOW2: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            bit_nxt = bit_inc;
            if (bit_inc <= 4'd8) begin
              // start of a bit slot: put the data bit, or the ACK slot level, on SDA
              if (bit_inc < 4'd8) begin
                if (cmd_r == i2cmbe_pkg::CMD_WRITE) begin
                  sda_nxt   = !shift_r[i2cmbe_pkg::BYTE_W-1];
                  shift_nxt = {shift_r[i2cmbe_pkg::BYTE_W-2:0], 1'b0};
                end else begin
                  sda_nxt = 1'b0;
                end
              end else if (cmd_r == i2cmbe_pkg::CMD_WRITE) begin
                sda_nxt = 1'b0;
              end else begin
                sda_nxt = cmd_r == i2cmbe_pkg::CMD_RD_ACK;
              end
              phase_nxt = PH_SETTLE;
            end else begin
              done      = 1'b1;
              phase_nxt = PH_IDLE;
              cmd_nxt   = i2cmbe_pkg::CMD_NONE;
            end
          end
        end
        PH_STOP_HOLD: begin
          tick_nxt = wait_hit ? '0 : tick_inc;
          if (wait_hit) begin
            sda_nxt   = 1'b0;
            done      = 1'b1;
            phase_nxt = PH_IDLE;
            cmd_nxt   = i2cmbe_pkg::CMD_NONE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          cmd_nxt   = i2cmbe_pkg::CMD_NONE;
        end
      endcase
    end
  end

  always_comb begin
    res.scl_low         = scl_nxt;
    res.sda_low         = sda_nxt;
    res.busy_res        = phase_nxt != PH_IDLE;
    res.done_res        = done;
    res.rd_byte         = rd_nxt;
    res.ack_seen        = ack_nxt;
    res.stretch_timeout = tout_nxt;
    out_vld_nxt = pop ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      cmd_r     <= i2cmbe_pkg::CMD_NONE;
      bit_r     <= '0;
      shift_r   <= '0;
      rd_r      <= '0;
      tick_r    <= '0;
      str_r     <= '0;
      scl_r     <= 1'b0;
      sda_r     <= 1'b0;
      ack_r     <= 1'b0;
      tout_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      cmd_r     <= cmd_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      rd_r      <= rd_nxt;
      tick_r    <= tick_nxt;
      str_r     <= str_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
      ack_r     <= ack_nxt;
      tout_r    <= tout_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= res;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.scl_low         = out_r.scl_low;
  assign out_ch.sda_low         = out_r.sda_low;
  assign out_ch.busy_res        = out_r.busy_res;
  assign out_ch.done_res        = out_r.done_res;
  assign out_ch.rd_byte         = out_r.rd_byte;
  assign out_ch.ack_seen        = out_r.ack_seen;
  assign out_ch.stretch_timeout = out_r.stretch_timeout;

endmodule

`default_nettype wire

/* rtl/i2cmbe_checker.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - port checker
// Port-level properties of the engine, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_master_bit_engine_core_defines.svh"

module i2cmbe_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                out_scl_low,
  input logic                                out_sda_low,
  input logic                                out_busy,
  input logic                                out_done,
  input logic [i2cmbe_pkg::BYTE_W-1:0]       out_rd_byte,
  input logic                                out_ack,
  input logic                                out_tout
);

  // a stalled result holds
  `I2CMBE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({out_scl_low, out_sda_low, out_busy, out_done, out_rd_byte, out_ack, out_tout}), "result changed while stalled")

  // completion tick leaves the engine idle
  `I2CMBE_ASSERT_NOW(a_done_idle, out_valid && out_done, !out_busy, "done while still busy")

  // when idle, SDA is never held low with SCL released
  `I2CMBE_ASSERT_NOW(a_idle_bus, out_valid && !out_busy && out_sda_low, out_scl_low, "idle with SDA low and SCL released")

endmodule

bind i2c_master_bit_engine_core i2cmbe_checker u_i2cmbe_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_scl_low (out_ch.scl_low),
  .out_sda_low (out_ch.sda_low),
  .out_busy    (out_ch.busy_res),
  .out_done    (out_ch.done_res),
  .out_rd_byte (out_ch.rd_byte),
  .out_ack     (out_ch.ack_seen),
  .out_tout    (out_ch.stretch_timeout)
);

`default_nettype wire

/* verif/i2c_master_bit_engine_core_test.sv */
// ---------------------------------------------------------------------------
// I2C master bit engine - block-level testbench
// Drives timer ticks with modelled SCL/SDA levels into the engine, predicts
// every status transaction in a cycle-free model of the bit sequencer and
// compares each returned transaction field by field, with random idling on
// both channels, receiver hold-off and several timing configurations.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_core_test;
  import i2cmbe_pkg::*;

  // run control
  localparam int unsigned STALL_LIMIT    = 2000;  // cycles with no transaction at all
  localparam int unsigned RX_HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int unsigned TAIL_CYCLES    = 8;     // two-stage pipe plus margin
  localparam int unsigned MAX_REPORTS    = 40;

  // op codes the engine does not define; it must ignore them
  localparam logic [OP_W-1:0]      OP_RSVD6   = 3'd6;
  localparam logic [OP_W-1:0]      OP_RSVD7   = 3'd7;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;

  // sequencer phases of the prediction
  typedef enum logic [3:0] {
    ST_IDLE, ST_START_HOLD, ST_START_SDA, ST_SETTLE, ST_STRETCH,
    ST_HIGH1, ST_HIGH2, ST_LOW1, ST_LOW2, ST_STOP_SET, ST_STOP_HOLD
  } seq_state_e;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  i2cmbe_in_if  in_ch ();
  i2cmbe_out_if out_ch ();

  i2c_master_bit_engine_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // -------------------------------------------------------------------------
  // Engine prediction: register copies and sequencer state
  // -------------------------------------------------------------------------
  logic [CFG_W-1:0]  base_cfg, settle_cfg, limit_cfg;
  seq_state_e        eng_state;
  logic [OP_W-1:0]   eng_cmd;
  logic [3:0]        eng_bit;      // 15 = pre-slot low phase, 8 = ACK slot
  logic [BYTE_W-1:0] eng_shift;
  logic [BYTE_W-1:0] eng_rd;
  logic [CFG_W-1:0]  eng_ticks;
  logic [CFG_W-1:0]  eng_stretch;
  logic              eng_scl_low, eng_sda_low, eng_ack, eng_tmo;

  res_t due_status[$];             // status transactions still to come back

  // stimulus and bookkeeping
  bit          offering;           // in_ch.valid is being held high
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          rx_hold_req;
  bit          bus_held;           // a start went out with no stop since
  int unsigned sent_ticks;
  int unsigned checked_ticks;
  int unsigned mismatches;
  int unsigned cmds_done, acks_seen, stretch_timeouts, rx_holds;
  int unsigned stall_cycles;

  task automatic reset_engine_model();
    base_cfg    = BASE_RST;
    settle_cfg  = SETTLE_RST;
    limit_cfg   = STRETCH_RST;
    eng_state   = ST_IDLE;
    eng_cmd     = CMD_NONE;
    eng_bit     = '0;
    eng_shift   = '0;
    eng_rd      = '0;
    eng_ticks   = '0;
    eng_stretch = '0;
    eng_scl_low = 1'b0;
    eng_sda_low = 1'b0;
    eng_ack     = 1'b0;
    eng_tmo     = 1'b0;
  endtask

  // Timed wait: counts this tick, true once n ticks (at least one) have gone.
  function automatic logic phase_elapsed(input logic [CFG_W-1:0] n);
    logic [CFG_W-1:0] lim;
    lim = (n == '0) ? 16'd1 : n;
    eng_ticks = eng_ticks + 16'd1;
    if (eng_ticks >= lim) begin
      eng_ticks = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Set SDA for the slot in eng_bit and go to the settle wait.
  task automatic open_bit_slot();
    if (eng_bit < 4'd8) begin
      if (eng_cmd == CMD_WRITE) begin
        eng_sda_low = !eng_shift[7];
        eng_shift   = {eng_shift[6:0], 1'b0};
      end else begin
        eng_sda_low = 1'b0;
      end
    end else if (eng_cmd == CMD_WRITE) begin
      eng_sda_low = 1'b0;                      // let the slave answer
    end else begin
      eng_sda_low = (eng_cmd == CMD_RD_ACK);   // ACK low, NAK released
    end
    eng_ticks = '0;
    eng_state = ST_SETTLE;
  endtask

  // One timer tick through the sequencer; queues the status it must produce.
  task automatic step_bit_engine(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wr,
                                 input logic scl, input logic sda);
    res_t r;
    logic fin;
    fin = 1'b0;
    case (eng_state)
      ST_IDLE: begin
        if (op >= CMD_START && op <= CMD_STOP) begin
          eng_cmd   = op;
          eng_tmo   = 1'b0;
          eng_ticks = '0;
          if (op == CMD_START) begin
            eng_scl_low = 1'b0;
            eng_sda_low = 1'b0;
            eng_bit     = 4'd8;
            eng_state   = ST_START_HOLD;
          end else if (op == CMD_STOP) begin
            eng_scl_low = 1'b1;
            eng_sda_low = 1'b1;
            eng_state   = ST_STOP_SET;
          end else begin
            if (op == CMD_WRITE) begin
              eng_shift = wr;
              eng_ack   = 1'b0;
            end else begin
              eng_shift = '0;
            end
            eng_scl_low = 1'b1;
            eng_sda_low = 1'b1;
            eng_bit     = 4'd15;
            eng_state   = ST_LOW1;
          end
        end
      end
      ST_START_HOLD: begin
        if (phase_elapsed(base_cfg)) begin
          eng_sda_low = 1'b1;
          eng_state   = ST_START_SDA;
        end
      end
      ST_START_SDA: begin
        if (phase_elapsed(base_cfg)) begin
          eng_scl_low = 1'b1;
          eng_state   = ST_LOW1;
        end
      end
      ST_SETTLE, ST_STOP_SET: begin
        if (phase_elapsed(settle_cfg)) begin
          eng_scl_low = 1'b0;
          eng_stretch = '0;
          eng_state   = ST_STRETCH;
        end
      end
      ST_STRETCH: begin
        if (!scl && eng_stretch < limit_cfg) begin
          eng_stretch = eng_stretch + 16'd1;
        end else begin
          if (!scl) begin
            eng_tmo = 1'b1;
            stretch_timeouts++;
          end
          eng_ticks = '0;
          eng_state = (eng_cmd == CMD_STOP) ? ST_STOP_HOLD : ST_HIGH1;
        end
      end
      ST_HIGH1: begin
        if (phase_elapsed(base_cfg)) begin
          if ((eng_cmd == CMD_RD_ACK || eng_cmd == CMD_RD_NAK) && eng_bit < 4'd8) begin
            eng_shift = {eng_shift[6:0], sda};
            if (eng_bit == 4'd7) eng_rd = eng_shift;
          end else if (eng_cmd == CMD_WRITE && eng_bit == 4'd8) begin
            eng_ack = !sda;
            if (!sda) acks_seen++;
          end
          eng_state = ST_HIGH2;
        end
      end
      ST_HIGH2: begin
        if (phase_elapsed(base_cfg)) begin
          eng_scl_low = 1'b1;
          eng_state   = ST_LOW1;
        end
      end
      ST_LOW1: begin
        if (phase_elapsed(base_cfg)) eng_state = ST_LOW2;
      end
      ST_LOW2: begin
        if (phase_elapsed(base_cfg)) begin
          eng_bit = eng_bit + 4'd1;
          if (eng_bit <= 4'd8) begin
            open_bit_slot();
          end else begin
            fin       = 1'b1;
            eng_state = ST_IDLE;
            eng_cmd   = CMD_NONE;
          end
        end
      end
      ST_STOP_HOLD: begin
        if (phase_elapsed(base_cfg)) begin
          eng_sda_low = 1'b0;
          fin         = 1'b1;
          eng_state   = ST_IDLE;
          eng_cmd     = CMD_NONE;
        end
      end
      default: begin
        eng_state = ST_IDLE;
        eng_cmd   = CMD_NONE;
      end
    endcase
    if (fin) cmds_done++;
    r.scl_low         = eng_scl_low;
    r.sda_low         = eng_sda_low;
    r.busy_res        = (eng_state != ST_IDLE);
    r.done_res        = fin;
    r.rd_byte         = eng_rd;
    r.ack_seen        = eng_ack;
    r.stretch_timeout = eng_tmo;
    due_status.push_back(r);
  endtask

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------

  // Offer one tick transaction; predict it on the edge it is taken.
  task automatic send_tick(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wr,
                           input logic scl, input logic sda);
    int unsigned gap;
    gap = tx_idle_en ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      if (offering) in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.wr_byte <= wr;
    in_ch.scl_in  <= scl;
    in_ch.sda_in  <= sda;
    offering = 1'b1;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sent_ticks++;
    step_bit_engine(op, wr, scl, sda);
  endtask

  // Drop valid and wait until every queued status transaction is back.
  task automatic drain_results();
    if (offering) in_ch.valid <= 1'b0;
    offering = 1'b0;
    @(posedge clk);
    while (due_status.size() != 0) @(posedge clk);
  endtask

  // Issue a command and keep ticking until the engine is idle again. The
  // slave side is modelled on the wired-AND bus: SCL follows our drive unless
  // the slave stretches, SDA carries slave_byte MSB first, then the ACK level.
  // Ops offered while busy are random and must be ignored.
  task automatic drive_command(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wr,
                               input logic [BYTE_W-1:0] slave_byte, input logic slave_acks,
                               input int unsigned hold_pct, input bit noise);
    logic            scl, sda;
    logic [OP_W-1:0] cur_op;
    cur_op = op;
    do begin
      scl = !eng_scl_low &&
            !(eng_state == ST_STRETCH && $urandom_range(0, 99) < hold_pct);
      sda = !eng_sda_low &&
            ((eng_bit < 4'd8) ? slave_byte[3'd7 - eng_bit[2:0]] : !slave_acks);
      if (noise && $urandom_range(0, 19) == 0) begin
        scl = $urandom_range(0, 1);
        sda = $urandom_range(0, 1);
      end
      send_tick(cur_op, wr, scl, sda);
      cur_op = $urandom_range(0, 7);
      wr     = $urandom_range(0, 255);
    end while (eng_state != ST_IDLE);
  endtask

  // Register writes, only with the engine idle and nothing outstanding.
  task automatic set_config(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] settle,
                            input logic [CFG_W-1:0] limit);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_idx   <= CFG_SETTLE;
    cfg_wdata <= settle;
    @(posedge clk);
    cfg_idx   <= CFG_STRETCH;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_idx   <= CFG_SPARE;           // must not land anywhere
    cfg_wdata <= $urandom_range(0, 65535);
    @(posedge clk);
    cfg_we    <= 1'b0;
    base_cfg   = base;
    settle_cfg = settle;
    limit_cfg  = limit;
  endtask

  function automatic logic [OP_W-1:0] junk_op();
    case ($urandom_range(0, 2))
      0:       return CMD_NONE;
      1:       return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

  // Mostly well-formed traffic: start, bytes, repeated start, stop.
  function automatic logic [OP_W-1:0] pick_command();
    int unsigned     roll;
    logic [OP_W-1:0] op;
    roll = $urandom_range(0, 99);
    if (roll < 5)         op = $urandom_range(0, 7);
    else if (!bus_held)   op = CMD_START;
    else if (roll < 45)   op = CMD_WRITE;
    else if (roll < 60)   op = CMD_RD_ACK;
    else if (roll < 72)   op = CMD_RD_NAK;
    else if (roll < 84)   op = CMD_START;
    else                  op = CMD_STOP;
    if (op == CMD_START)     bus_held = 1'b1;
    else if (op == CMD_STOP) bus_held = 1'b0;
    return op;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Reset timing: ignored ops on an idle engine, then a stop on a released bus.
  task automatic test_reset_defaults();
    send_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
    send_tick(OP_RSVD6, 8'hFF, 1'b1, 1'b1);
    send_tick(OP_RSVD7, 8'h00, 1'b1, 1'b0);
    drive_command(CMD_STOP, 8'hFF, 8'hFF, 1'b0, 0, 1'b0);
  endtask

  // Zero waits everywhere, zero stretch limit: every op, byte extremes.
  task automatic test_zero_timing();
    set_config(16'd0, 16'd0, 16'd0);
    drive_command(CMD_START,  8'h00, 8'hFF, 1'b0, 0, 1'b0);
    drive_command(CMD_WRITE,  8'hFF, 8'hFF, 1'b0, 0, 1'b0);   // slave NAKs
    drive_command(CMD_WRITE,  8'h00, 8'hFF, 1'b1, 0, 1'b0);   // slave ACKs
    drive_command(CMD_RD_ACK, 8'h00, 8'hA5, 1'b0, 0, 1'b0);
    drive_command(CMD_RD_NAK, 8'hFF, 8'h5A, 1'b0, 0, 1'b0);
    drive_command(CMD_RD_ACK, 8'h00, 8'hFF, 1'b0, 0, 1'b0);
    drive_command(CMD_START,  8'h00, 8'h00, 1'b0, 0, 1'b0);   // repeated start
    // SCL held low by the slave: limit 0 gives up on the first low tick
    drive_command(CMD_WRITE,  8'h3C, 8'h00, 1'b1, 100, 1'b0);
    drive_command(CMD_STOP,   8'h00, 8'h00, 1'b0, 100, 1'b0);
  endtask

  // Real stretch waits below and beyond a small limit.
  task automatic test_stretch_wait();
    set_config(16'd1, 16'd2, 16'd3);
    drive_command(CMD_START,  8'h00, 8'h00, 1'b0, 50, 1'b0);
    drive_command(CMD_RD_ACK, 8'h00, 8'hC3, 1'b0, 100, 1'b0);
    drive_command(CMD_WRITE,  8'h81, 8'h00, 1'b1, 60, 1'b0);
    drive_command(CMD_STOP,   8'h00, 8'h00, 1'b0, 0, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned budget, input int unsigned hold_pct,
                                     input bit noise);
    int unsigned first, ignored;
    first   = sent_ticks;
    ignored = 0;
    while (sent_ticks - first - ignored < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        drive_command(junk_op(), $urandom_range(0, 255), 8'h00, 1'b0, hold_pct, 1'b1);
        ignored++;
      end else begin
        drive_command(pick_command(), $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 1), hold_pct, noise);
      end
    end
  endtask

  // Ticks back to back on both sides.
  task automatic test_back_to_back();
    set_config(16'd2, 16'd1, 16'd5);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(100, 20, 1'b0);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver holds off while ticks keep coming: the queue fills, input stalls.
  task automatic test_output_backpressure();
    set_config(16'd1, 16'd0, 16'd3);
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    test_random_traffic(100, 30, 1'b0);
    tx_idle_en  = 1'b1;
  endtask

  // All registers at their top value: one stop runs two full-length waits.
  task automatic test_long_phases();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    drive_command(CMD_STOP, 8'h00, 8'h00, 1'b0, 0, 1'b0);
    bus_held   = 1'b0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // -------------------------------------------------------------------------
  // Result side: receiver with random hold-off, checker, watchdog
  // -------------------------------------------------------------------------

  task automatic log_mismatch(input string what, input int unsigned got,
                              input int unsigned want);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH status transaction %0d: %s got 0x%0h want 0x%0h",
               checked_ticks, what, got, want);
    mismatches++;
  endtask

  initial begin : result_sink
    int unsigned pause;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      pause = rx_idle_en ? $urandom_range(0, 11) : 0;
      if (rx_hold_req) begin
        pause       = RX_HOLD_CYCLES;
        rx_hold_req = 1'b0;
        rx_holds++;
      end
      if (pause != 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Every accepted status transaction against the oldest prediction.
  always @(posedge clk) begin : status_check
    res_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (due_status.size() == 0) begin
        log_mismatch("transaction with no tick outstanding", 0, 0);
      end else begin
        want = due_status.pop_front();
        if (out_ch.scl_low !== want.scl_low)
          log_mismatch("scl_low", out_ch.scl_low, want.scl_low);
        if (out_ch.sda_low !== want.sda_low)
          log_mismatch("sda_low", out_ch.sda_low, want.sda_low);
        if (out_ch.busy_res !== want.busy_res)
          log_mismatch("busy_res", out_ch.busy_res, want.busy_res);
        if (out_ch.done_res !== want.done_res)
          log_mismatch("done_res", out_ch.done_res, want.done_res);
        if (out_ch.rd_byte !== want.rd_byte)
          log_mismatch("rd_byte", out_ch.rd_byte, want.rd_byte);
        if (out_ch.ack_seen !== want.ack_seen)
          log_mismatch("ack_seen", out_ch.ack_seen, want.ack_seen);
        if (out_ch.stretch_timeout !== want.stretch_timeout)
          log_mismatch("stretch_timeout", out_ch.stretch_timeout, want.stretch_timeout);
      end
      checked_ticks++;
    end
  end

  // Any transaction on either channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d status transactions outstanding",
               stall_cycles, due_status.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // -------------------------------------------------------------------------
  // Sequence
  // -------------------------------------------------------------------------
  initial begin : run
    in_ch.valid   = 1'b0;
    in_ch.op      = CMD_NONE;
    in_ch.wr_byte = '0;
    in_ch.scl_in  = 1'b1;
    in_ch.sda_in  = 1'b1;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_BASE;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    stall_cycles  = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    reset_engine_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_zero_timing();
    test_stretch_wait();

    set_config(16'd1, 16'd0, 16'd2);
    test_random_traffic(200, 30, 1'b0);
    set_config(16'd2, 16'd1, 16'hFFFF);
    test_random_traffic(200, 20, 1'b1);
    set_config(16'd0, 16'd3, 16'd1);
    test_random_traffic(200, 40, 1'b1);

    test_back_to_back();
    test_output_backpressure();
    test_long_phases();

    // let the pipe empty, then give stray transactions a chance to show
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d ticks through start/write/read/stop sequences: %0d commands done,",
             sent_ticks, cmds_done);
    $display("%0d ACKs, %0d stretch timeouts, %0d long receiver hold-offs, %0d mismatches",
             acks_seen, stretch_timeouts, rx_holds, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
